>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and default sizes shared by the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned SPQ_DEPTH      = 16;
  localparam int unsigned SPQ_VALUE_BITS = 8;

  // Fixed field widths of the channels
  localparam int unsigned ITEM_VALUE_W = 8;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 5;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } spq_func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

`default_nettype wire

>>> design/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: operation code, value and priority with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [ITEM_VALUE_W-1:0] item_value;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (output valid, func, item_value, item_priority, input ready);
  modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

`default_nettype wire

>>> design/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: removed entry, status and occupancy with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if
  import spq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ITEM_VALUE_W-1:0]  out_value;
  logic signed [PRIO_W-1:0] out_priority;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, out_value, out_priority, status, occupancy,
                  input ready);
  modport sink   (input valid, out_value, out_priority, status, occupancy,
                  output ready);
endinterface

`default_nettype wire

>>> design/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Priority queue held as a row of cells sorted by ascending priority.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle and its response appears in the result
// register on the next cycle; a request is refused only while a response
// still waits to be taken. This comes from the cell row: every cell compares
// its priority with the new one in parallel and the row shifts right on
// enqueue (from the insertion point) or left on dequeue all at once. Equal
// priorities put the newest entry first. An enqueue to a full queue is
// dropped with status full; a dequeue from an empty queue returns zeros with
// status empty. Occupancy is reported in 5 bits and wraps for DEPTH above 31.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH      = SPQ_DEPTH,
  parameter int unsigned VALUE_BITS = SPQ_VALUE_BITS
) (
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [VALUE_BITS-1:0]    cell_value [DEPTH];
  logic signed [PRIO_W-1:0] cell_prio  [DEPTH];
  logic                     cell_lt    [DEPTH];

  logic                    transfer;
  logic                    full;
  logic                    empty;
  spq_ctrl_t               ctrl;
  logic [VALUE_BITS-1:0]   new_value;
  logic [VALUE_BITS+ITEM_VALUE_W-1:0] value_in_wide;
  logic [VALUE_BITS+ITEM_VALUE_W-1:0] value_out_wide;
  logic [CW+OCC_W-1:0]     occ_wide;

  logic                     rsp_valid;
  logic [ITEM_VALUE_W-1:0]  rsp_value;
  logic signed [PRIO_W-1:0] rsp_prio;
  spq_status_t              rsp_status;
  logic [OCC_W-1:0]         rsp_occ;

  assign req.ready = !rsp_valid || rsp.ready;
  assign transfer  = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  assign ctrl.enq = transfer && (req.func == FUNC_ENQ) && !full;
  assign ctrl.deq = transfer && (req.func == FUNC_DEQ) && !empty;

  // Value port is fixed width; the store keeps VALUE_BITS of it
  assign value_in_wide  = {{VALUE_BITS{1'b0}}, req.item_value};
  assign new_value      = value_in_wide[VALUE_BITS-1:0];
  assign value_out_wide = {{ITEM_VALUE_W{1'b0}}, cell_value[0]};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_lt;
    logic [VALUE_BITS-1:0]    left_value;
    logic signed [PRIO_W-1:0] left_prio;
    logic [VALUE_BITS-1:0]    right_value;
    logic signed [PRIO_W-1:0] right_prio;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = new_value;
      assign left_prio  = req.item_priority;
    end else begin : g_body
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CW'(i) < count),
      .new_value   (new_value),
      .new_prio    (req.item_priority),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .left_prio   (left_prio),
      .right_value (right_value),
      .right_prio  (right_prio),
      .value       (cell_value[i]),
      .prio        (cell_prio[i]),
      .lt          (cell_lt[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CW'(1);
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (transfer) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (transfer) begin
      rsp_occ <= occ_wide[OCC_W-1:0];
      if (ctrl.deq) begin
        rsp_value  <= value_out_wide[ITEM_VALUE_W-1:0];
        rsp_prio   <= cell_prio[0];
        rsp_status <= STATUS_DONE;
      end else begin
        rsp_value <= '0;
        rsp_prio  <= '0;
        if (req.func == FUNC_DEQ) begin
          rsp_status <= STATUS_EMPTY;
        end else if (full) begin
          rsp_status <= STATUS_FULL;
        end else begin
          rsp_status <= STATUS_DONE;
        end
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.out_value    = rsp_value;
  assign rsp.out_priority = rsp_prio;
  assign rsp.status       = rsp_status;
  assign rsp.occupancy    = rsp_occ;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.enq |=> count == $past(count) + CW'(1))
    else $error("enqueue did not grow the count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (transfer && req.func == FUNC_DEQ && empty) |=>
      (rsp.status == STATUS_EMPTY && rsp.out_value == '0))
    else $error("dequeue on empty not flagged");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cell_prio[0] <= cell_prio[1]))
    else $error("head of queue out of order");
`endif

endmodule

`default_nettype wire

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: compares against the new priority and either
// keeps its entry, takes the new one, or takes a neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned VALUE_BITS = SPQ_VALUE_BITS
) (
  input  wire logic                     clk,
  input  wire spq_ctrl_t                ctrl,
  input  wire logic                     occupied,
  input  wire logic [VALUE_BITS-1:0]    new_value,
  input  wire logic signed [PRIO_W-1:0] new_prio,
  input  wire logic                     left_lt,
  input  wire logic [VALUE_BITS-1:0]    left_value,
  input  wire logic signed [PRIO_W-1:0] left_prio,
  input  wire logic [VALUE_BITS-1:0]    right_value,
  input  wire logic signed [PRIO_W-1:0] right_prio,
  output logic [VALUE_BITS-1:0]         value,
  output logic signed [PRIO_W-1:0]      prio,
  output logic                          lt
);

  logic [VALUE_BITS-1:0]    value_next;
  logic signed [PRIO_W-1:0] prio_next;

  // Stays put while strictly ahead of the new item
  assign lt = occupied && (prio < new_prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    if (ctrl.enq) begin
      if (!lt) begin
        if (left_lt) begin
          value_next = new_value;
          prio_next  = new_prio;
        end else begin
          value_next = left_value;
          prio_next  = left_prio;
        end
      end
    end else if (ctrl.deq) begin
      value_next = right_value;
      prio_next  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

`default_nettype wire

>>> dv/sorted_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. A directed table covers
// an empty dequeue, extreme priorities, equal-priority ordering and an
// enqueue to a full queue. Random bursts of enqueues and dequeues follow.
// Each response is compared field by field with its typed row or a behavioural
// copy of the store, under three settings of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH       = SPQ_DEPTH;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RAND_ITEMS  = 1100;

  typedef struct {
    logic [ITEM_VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
    spq_status_t              status;
    logic [OCC_W-1:0]         occ;
  } queue_rsp_t;

  typedef struct packed {
    spq_func_t                func;
    logic [ITEM_VALUE_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
    logic                     typed;
    spq_status_t              status;
    logic [ITEM_VALUE_W-1:0]  out_value;
    logic signed [PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]         occ;
  } dir_row_t;

  // Expected response typed in only where obvious; the rest comes from the
  // predictor.
  localparam dir_row_t DIRECTED [23] = '{
    '{FUNC_DEQ, 8'h00, 16'sh0000, 1'b1, STATUS_EMPTY, 8'h00, 16'sh0000, 5'd0},
    '{FUNC_ENQ, 8'hff, 16'sh7fff, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd1},
    '{FUNC_ENQ, 8'h00, 16'sh8000, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd2},
    '{FUNC_ENQ, 8'h5a, 16'sh0000, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd3},
    '{FUNC_ENQ, 8'ha5, 16'sh0000, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd4},
    '{FUNC_DEQ, 8'h7e, 16'sh1234, 1'b1, STATUS_DONE,  8'h00, 16'sh8000, 5'd3},
    '{FUNC_DEQ, 8'h81, 16'shffff, 1'b0, STATUS_DONE,  8'h00, 16'sh0000, 5'd0},
    '{FUNC_ENQ, 8'h01, 16'sh7fff, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd3},
    '{FUNC_ENQ, 8'h02, 16'sh8000, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd4},
    '{FUNC_ENQ, 8'h04, 16'shffff, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd5},
    '{FUNC_ENQ, 8'h08, 16'sh0001, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd6},
    '{FUNC_ENQ, 8'h10, 16'sh0000, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd7},
    '{FUNC_ENQ, 8'h20, 16'sh0064, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd8},
    '{FUNC_ENQ, 8'h40, 16'shff9c, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd9},
    '{FUNC_ENQ, 8'h80, 16'sh7ffe, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd10},
    '{FUNC_ENQ, 8'hc3, 16'sh8001, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd11},
    '{FUNC_ENQ, 8'h3c, 16'sh0000, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd12},
    '{FUNC_ENQ, 8'h99, 16'sh0100, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd13},
    '{FUNC_ENQ, 8'h66, 16'shff00, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd14},
    '{FUNC_ENQ, 8'he7, 16'sh7f00, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd15},
    '{FUNC_ENQ, 8'h18, 16'sh0005, 1'b1, STATUS_DONE,  8'h00, 16'sh0000, 5'd16},
    '{FUNC_ENQ, 8'h55, 16'sh8000, 1'b1, STATUS_FULL,  8'h00, 16'sh0000, 5'd16},
    '{FUNC_DEQ, 8'h00, 16'sh0000, 1'b0, STATUS_DONE,  8'h00, 16'sh0000, 5'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_req_if req();
  spq_rsp_if rsp();

  sorted_priority_queue_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #2 clk = ~clk;

  // Shadow of the sorted store
  logic [ITEM_VALUE_W-1:0]  held_val [DEPTH];
  logic signed [PRIO_W-1:0] held_pri [DEPTH];
  int                       held = 0;

  queue_rsp_t due_rsp_q [$];
  int         errors     = 0;
  int         stall_cnt  = 0;
  int         gap_pct    = 10;
  int         hold_pct   = 49;
  logic       req_typed  = 1'b0;
  queue_rsp_t req_want;
  queue_rsp_t no_want;

  function automatic queue_rsp_t queue_apply(spq_func_t f, logic [ITEM_VALUE_W-1:0] v,
                                             logic signed [PRIO_W-1:0] p);
    queue_rsp_t r;
    int pos;
    int k;
    r.value  = '0;
    r.prio   = '0;
    r.status = STATUS_DONE;
    if (f == FUNC_ENQ) begin
      if (held >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // insert ahead of the first entry that is not smaller: newest tie first
        pos = 0;
        while (pos < held && held_pri[pos] < p) pos++;
        for (k = held; k > pos; k--) begin
          held_val[k] = held_val[k-1];
          held_pri[k] = held_pri[k-1];
        end
        held_val[pos] = v;
        held_pri[pos] = p;
        held++;
      end
    end else if (held == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.value = held_val[0];
      r.prio  = held_pri[0];
      for (k = 0; k + 1 < held; k++) begin
        held_val[k] = held_val[k+1];
        held_pri[k] = held_pri[k+1];
      end
      held--;
    end
    r.occ = held[OCC_W-1:0];
    return r;
  endfunction

  task automatic check_fld(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver: stalls at the current rate
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= hold_pct);
  end

  // Transfer monitor, predictor feed, response check and watchdog
  always @(posedge clk) begin
    queue_rsp_t want;
    queue_rsp_t calc;
    if (!rst) begin
      if (req.valid && req.ready) begin
        calc = queue_apply(spq_func_t'(req.func), req.item_value, req.item_priority);
        due_rsp_q.push_back(req_typed ? req_want : calc);
      end
      if (rsp.valid && rsp.ready) begin
        if (due_rsp_q.size() == 0) begin
          $display("%0t: unexpected response, value %0d priority %0d status %0d occ %0d",
                   $time, rsp.out_value, rsp.out_priority, rsp.status, rsp.occupancy);
          errors++;
        end else begin
          want = due_rsp_q.pop_front();
          check_fld("out_value", want.value, rsp.out_value);
          check_fld("out_priority", want.prio, rsp.out_priority);
          check_fld("status", want.status, rsp.status);
          check_fld("occupancy", want.occ, rsp.occupancy);
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(spq_func_t f, logic [ITEM_VALUE_W-1:0] v,
                           logic signed [PRIO_W-1:0] p, logic typed, queue_rsp_t want);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid         <= 1'b1;
    req.func          <= f;
    req.item_value    <= v;
    req.item_priority <= p;
    req_typed         <= typed;
    req_want          <= want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_prio();
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(3))
      0: p = PRIO_W'(int'($urandom_range(4)) - 2);  // narrow band, plenty of ties
      1: begin
        case ($urandom_range(3))
          0: p = 16'sh7fff;
          1: p = 16'sh8000;
          2: p = 16'shffff;
          default: p = 16'sh0000;
        endcase
      end
      default: p = PRIO_W'($urandom);
    endcase
    return p;
  endfunction

  // Bursts long enough to fill past full or drain past empty, plus noise
  task automatic run_random(int n_items);
    int sent;
    int kind;
    int len;
    spq_func_t f;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      len  = $urandom_range(1, DEPTH + 3);
      repeat (len) begin
        if (kind < 4) f = FUNC_ENQ;
        else if (kind < 8) f = FUNC_DEQ;
        else f = spq_func_t'($urandom_range(1));
        send_item(f, ITEM_VALUE_W'($urandom), pick_prio(), 1'b0, no_want);
        sent++;
      end
    end
  endtask

  initial begin
    queue_rsp_t want;
    req.valid         = 1'b0;
    req.func          = FUNC_ENQ;
    req.item_value    = '0;
    req.item_priority = '0;
    rsp.ready         = 1'b0;
    no_want.value     = '0;
    no_want.prio      = '0;
    no_want.status    = STATUS_DONE;
    no_want.occ       = '0;
    req_want          = no_want;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) begin
      want.value  = DIRECTED[i].out_value;
      want.prio   = DIRECTED[i].out_prio;
      want.status = DIRECTED[i].status;
      want.occ    = DIRECTED[i].occ;
      send_item(DIRECTED[i].func, DIRECTED[i].value, DIRECTED[i].prio,
                DIRECTED[i].typed, want);
    end

    run_random(RAND_ITEMS / 3);
    gap_pct  = 49;
    hold_pct = 10;
    run_random(RAND_ITEMS / 3);
    gap_pct  = 0;
    hold_pct = 0;
    run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));

    @(negedge clk);
    req.valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/spq_pkg.sv
design/spq_req_if.sv
design/spq_rsp_if.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
dv/sorted_priority_queue_top_tb.sv
